### sv/slab_slot_allocator_defines.svh
// Assertion macros for the slab slot allocator port checker
`ifndef SLAB_SLOT_ALLOCATOR_DEFINES_SVH
`define SLAB_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low
`define SSA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slab_slot_allocator: port check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define SSA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slab_slot_allocator: port check failed");

`endif

### sv/ssa_pkg.sv
// Types, constants and helpers for the slab slot allocator
package ssa_pkg;

  // Pool geometry
  localparam int PAGES          = 16;
  localparam int SLOTS_PER_PAGE = 64;

  // Port field widths
  localparam int PAGE_W  = 4;
  localparam int SLOT_W  = 6;
  localparam int TOTAL_W = 11;

  // Derived widths
  localparam int PIDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int SIDX_W = $clog2(SLOTS_PER_PAGE);
  localparam int LINK_W = $clog2(PAGES + 1);
  localparam int CNT_W  = $clog2(SLOTS_PER_PAGE + 1);

  typedef logic [LINK_W-1:0] link_t;

  // Null link code
  localparam link_t NIL = link_t'(PAGES);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOTS_PER_PAGE);

  // Request codes
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_ADD   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_SLOT = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // Page list tags
  localparam logic [1:0] TAG_NONE  = 2'd0;
  localparam logic [1:0] TAG_EMPTY = 2'd1;
  localparam logic [1:0] TAG_PART  = 2'd2;
  localparam logic [1:0] TAG_FULL  = 2'd3;

  // List indexes for the head/tail registers
  localparam int LIST_N = 3;
  localparam logic [1:0] LIST_EMPTY = 2'd0;
  localparam logic [1:0] LIST_PART  = 2'd1;
  localparam logic [1:0] LIST_FULL  = 2'd2;

  // Per-page record: list tag, free count, busy bitmap
  typedef struct packed {
    logic [1:0]                tag;
    logic [CNT_W-1:0]          count;
    logic [SLOTS_PER_PAGE-1:0] busy;
  } page_rec_t;

  // Write ports of the page and link memories
  typedef struct packed {
    logic              page_we;
    logic [PIDX_W-1:0] page_addr;
    page_rec_t         page_wdata;
    logic              next_we;
    logic [PIDX_W-1:0] next_addr;
    link_t             next_wdata;
    logic              prev_we;
    logic [PIDX_W-1:0] prev_addr;
    link_t             prev_wdata;
  } store_wr_t;

  // Registered read data, one entry of each memory
  typedef struct packed {
    page_rec_t page;
    link_t     next;
    link_t     prev;
  } store_rd_t;

  // One result word
  typedef struct packed {
    logic [1:0]         status;
    logic [PAGE_W-1:0]  page;
    logic [SLOT_W-1:0]  slot;
    logic [TOTAL_W-1:0] free_total;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LINK_A,
    S_LINK_B,
    S_FINISH
  } state_t;

  // Map a list tag to its head/tail register index
  function automatic logic [1:0] tag_list(input logic [1:0] tag);
    logic [1:0] idx;
    case (tag)
      TAG_EMPTY: idx = LIST_EMPTY;
      TAG_PART:  idx = LIST_PART;
      TAG_FULL:  idx = LIST_FULL;
      default:   idx = LIST_EMPTY;
    endcase
    return idx;
  endfunction

endpackage

### sv/ssa_store.sv
// Page record memory and the next/prev link memories, registered read
module ssa_store (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [ssa_pkg::PIDX_W-1:0] rd_addr,
  input  ssa_pkg::store_wr_t        wr,
  output ssa_pkg::store_rd_t        rd
);
  import ssa_pkg::*;

  page_rec_t page_mem [PAGES];
  link_t     next_mem [PAGES];
  link_t     prev_mem [PAGES];

  page_rec_t page_q_r;
  link_t     next_q_r;
  link_t     prev_q_r;

  // Writes, one port per memory
  always_ff @(posedge clk) begin
    if (wr.page_we) begin
      page_mem[wr.page_addr] <= wr.page_wdata;
    end
    if (wr.next_we) begin
      next_mem[wr.next_addr] <= wr.next_wdata;
    end
    if (wr.prev_we) begin
      prev_mem[wr.prev_addr] <= wr.prev_wdata;
    end
  end

  // Registered reads, all three at the same page
  always_ff @(posedge clk) begin
    if (rd_en) begin
      page_q_r <= page_mem[rd_addr];
      next_q_r <= next_mem[rd_addr];
      prev_q_r <= prev_mem[rd_addr];
    end
  end

  assign rd = '{page: page_q_r, next: next_q_r, prev: prev_q_r};

endmodule

### sv/ssa_out_stage.sv
// Result register between the sequencer and the output channel
module ssa_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ld_valid,
  output logic             ld_ready,
  input  ssa_pkg::result_t ld_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ssa_pkg::result_t out_data
);
  import ssa_pkg::*;

  logic    valid_r;
  result_t data_r;

  // Free when empty or being drained this cycle
  assign ld_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld_ready) begin
      valid_r <= ld_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_valid && ld_ready) begin
      data_r <= ld_data;
    end
  end

endmodule

### sv/ssa_ctrl.sv
// Request sequencer: checks, slot update, list relinking, free total
module ssa_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_req_type,
  input  logic [ssa_pkg::PAGE_W-1:0] in_page_index,
  input  logic [ssa_pkg::SLOT_W-1:0] in_slot_index,
  output logic                       rd_en,
  output logic [ssa_pkg::PIDX_W-1:0] rd_addr,
  input  ssa_pkg::store_rd_t         rd,
  output ssa_pkg::store_wr_t         wr,
  output logic                       ld_valid,
  input  logic                       ld_ready,
  output ssa_pkg::result_t           ld_data
);
  import ssa_pkg::*;

  state_t              state_r, state_nxt;
  logic [1:0]          req_r, req_nxt;
  link_t               page_r, page_nxt;
  logic [SIDX_W-1:0]   slot_r, slot_nxt;
  logic                ok_r, ok_nxt;
  logic                unlink_r, unlink_nxt;
  link_t               pv_r, pv_nxt;
  link_t               nx_r, nx_nxt;
  link_t               head_r [LIST_N];
  link_t               head_nxt [LIST_N];
  link_t               tail_r [LIST_N];
  link_t               tail_nxt [LIST_N];
  logic [PAGES-1:0]    added_r, added_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  result_t             res_r, res_nxt;

  link_t               pick;
  logic                pg_ok;
  logic                sl_ok;
  logic                pg_added;
  page_rec_t           rec;
  page_rec_t           rec_new;
  logic                found;
  logic [SIDX_W-1:0]   zidx;
  logic [1:0]          new_tag;
  logic                done;
  logic                move;
  logic                unlink;
  logic [1:0]          lo;
  logic [1:0]          ln;
  link_t               t;

  // Lowest free slot of the page just read
  always_comb begin
    found = 1'b0;
    zidx  = '0;
    for (int i = SLOTS_PER_PAGE - 1; i >= 0; i--) begin
      if (!rd.page.busy[i]) begin
        found = 1'b1;
        zidx  = SIDX_W'(i);
      end
    end
  end

  // Next state and datapath
  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    page_nxt   = page_r;
    slot_nxt   = slot_r;
    ok_nxt     = ok_r;
    unlink_nxt = unlink_r;
    pv_nxt     = pv_r;
    nx_nxt     = nx_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    added_nxt  = added_r;
    total_nxt  = total_r;
    res_nxt    = res_r;
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr         = '0;
    ld_valid   = 1'b0;

    pick     = (head_r[LIST_PART] != NIL) ? head_r[LIST_PART] : head_r[LIST_EMPTY];
    pg_ok    = int'(in_page_index) < PAGES;
    sl_ok    = int'(in_slot_index) < SLOTS_PER_PAGE;
    pg_added = pg_ok && added_r[PIDX_W'(in_page_index)];

    rec     = rd.page;
    rec_new = rd.page;
    new_tag = rd.page.tag;
    done    = 1'b0;
    move    = 1'b0;
    unlink  = 1'b0;
    lo      = tag_list(rd.page.tag);
    ln      = lo;
    t       = NIL;

    case (state_r)
      // Take a request and read its page
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt  = in_req_type;
          slot_nxt = SIDX_W'(in_slot_index);
          case (in_req_type)
            REQ_ALLOC: begin
              page_nxt = pick;
              ok_nxt   = (pick != NIL);
            end
            REQ_FREE: begin
              page_nxt = LINK_W'(in_page_index);
              ok_nxt   = sl_ok && pg_added;
            end
            REQ_ADD: begin
              page_nxt = LINK_W'(in_page_index);
              ok_nxt   = pg_ok && !pg_added;
            end
            default: begin
              page_nxt = NIL;
              ok_nxt   = 1'b0;
            end
          endcase
          rd_en     = ok_nxt;
          rd_addr   = PIDX_W'(page_nxt);
          state_nxt = S_EXEC;
        end
      end

      // Update the page record, head/tail registers and first link writes
      S_EXEC: begin
        res_nxt.status = ST_INVALID;
        res_nxt.page   = '0;
        res_nxt.slot   = '0;
        case (req_r)
          REQ_ALLOC: begin
            res_nxt.status = ST_NO_SLOT;
            if (ok_r && found) begin
              rec_new.busy[zidx] = 1'b1;
              if (rec.count != '0) begin
                rec_new.count = rec.count - CNT_W'(1);
              end
              if (total_r != '0) begin
                total_nxt = total_r - TOTAL_W'(1);
              end
              new_tag        = (rec_new.count == '0) ? TAG_FULL : TAG_PART;
              res_nxt.status = ST_DONE;
              res_nxt.page   = PAGE_W'(page_r);
              res_nxt.slot   = SLOT_W'(zidx);
              done           = 1'b1;
            end
          end
          REQ_FREE: begin
            if (ok_r && rec.busy[slot_r]) begin
              rec_new.busy[slot_r] = 1'b0;
              if (rec.count < CNT_FULL) begin
                rec_new.count = rec.count + CNT_W'(1);
              end
              total_nxt      = total_r + TOTAL_W'(1);
              new_tag        = (rec_new.count == CNT_FULL) ? TAG_EMPTY : TAG_PART;
              res_nxt.status = ST_DONE;
              done           = 1'b1;
            end
          end
          REQ_ADD: begin
            if (ok_r) begin
              rec_new.busy   = '0;
              rec_new.count  = CNT_FULL;
              total_nxt      = total_r + TOTAL_W'(SLOTS_PER_PAGE);
              new_tag        = TAG_EMPTY;
              res_nxt.status = ST_DONE;
              done           = 1'b1;
              added_nxt[PIDX_W'(page_r)] = 1'b1;
            end
          end
          default: begin
            done = 1'b0;
          end
        endcase
        res_nxt.free_total = total_nxt;
        rec_new.tag        = new_tag;

        move   = done && ((req_r == REQ_ADD) || (rec.tag != new_tag));
        unlink = move && (req_r != REQ_ADD);

        // Page record write-back
        if (done) begin
          wr.page_we    = 1'b1;
          wr.page_addr  = PIDX_W'(page_r);
          wr.page_wdata = rec_new;
        end

        // Unlink from the old list, except for add-page, and append at the tail of the new one
        if (move) begin
          ln            = tag_list(new_tag);
          t             = tail_r[ln];
          wr.prev_we    = 1'b1;
          wr.prev_addr  = PIDX_W'(page_r);
          wr.prev_wdata = t;
          if (t != NIL) begin
            wr.next_we    = 1'b1;
            wr.next_addr  = PIDX_W'(t);
            wr.next_wdata = page_r;
          end
          if (unlink) begin
            if (rd.prev == NIL) begin
              head_nxt[lo] = rd.next;
            end
            if (rd.next == NIL) begin
              tail_nxt[lo] = rd.prev;
            end
          end
          if (t == NIL) begin
            head_nxt[ln] = page_r;
          end
          tail_nxt[ln] = page_r;
          pv_nxt       = rd.prev;
          nx_nxt       = rd.next;
          unlink_nxt   = unlink;
          state_nxt    = S_LINK_A;
        end else begin
          state_nxt = S_FINISH;
        end
      end

      // Terminate the moved page, patch the old successor's back link
      S_LINK_A: begin
        wr.next_we    = 1'b1;
        wr.next_addr  = PIDX_W'(page_r);
        wr.next_wdata = NIL;
        if (unlink_r && (nx_r != NIL)) begin
          wr.prev_we    = 1'b1;
          wr.prev_addr  = PIDX_W'(nx_r);
          wr.prev_wdata = pv_r;
        end
        state_nxt = unlink_r ? S_LINK_B : S_FINISH;
      end

      // Patch the old predecessor's forward link
      S_LINK_B: begin
        if (pv_r != NIL) begin
          wr.next_we    = 1'b1;
          wr.next_addr  = PIDX_W'(pv_r);
          wr.next_wdata = nx_r;
        end
        state_nxt = S_FINISH;
      end

      // Hand the result word to the output register
      S_FINISH: begin
        ld_valid = 1'b1;
        if (ld_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ld_data = res_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '{default: NIL};
      tail_r  <= '{default: NIL};
      added_r <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      added_r <= added_nxt;
      total_r <= total_nxt;
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    page_r   <= page_nxt;
    slot_r   <= slot_nxt;
    ok_r     <= ok_nxt;
    unlink_r <= unlink_nxt;
    pv_r     <= pv_nxt;
    nx_r     <= nx_nxt;
    res_r    <= res_nxt;
  end

endmodule

### sv/slab_slot_allocator.sv
// Slab slot allocator: a pool of up to 16 pages of 64 slots each, kept on three ordered
// lists (empty, partly used, full). Allocate grants the lowest free slot of the head of
// the partly-used list, or else of the empty list; free releases a slot; add-page puts a
// fresh page at the tail of the empty list. Every request returns one result word with a
// status, the granted page and slot, and the total free slots. Requests are handled one
// at a time: the page is read, then updated, then the result is loaded; add-page also
// passes through S_LINK_A, and an allocate or free that moves the page to another list
// through S_LINK_A and S_LINK_B, as the single write port of the next-link memory takes
// three writes for a relink. A finished result sits in an output register, so the next
// request is taken while it waits; a request stalls in S_FINISH only if that register
// is still full. Memories need no clearing after reset.
module slab_slot_allocator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_req_type,
  input  logic [ssa_pkg::PAGE_W-1:0] in_page_index,
  input  logic [ssa_pkg::SLOT_W-1:0] in_slot_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic [ssa_pkg::PAGE_W-1:0] out_granted_page,
  output logic [ssa_pkg::SLOT_W-1:0] out_granted_slot,
  output logic [ssa_pkg::TOTAL_W-1:0] out_free_total
);
  import ssa_pkg::*;

  logic              rd_en;
  logic [PIDX_W-1:0] rd_addr;
  store_rd_t         rd;
  store_wr_t         wr;
  logic              ld_valid;
  logic              ld_ready;
  result_t           ld_data;
  result_t           out_data;

  ssa_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_page_index (in_page_index),
    .in_slot_index (in_slot_index),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd            (rd),
    .wr            (wr),
    .ld_valid      (ld_valid),
    .ld_ready      (ld_ready),
    .ld_data       (ld_data)
  );

  ssa_store u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd      (rd)
  );

  ssa_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_valid  (ld_valid),
    .ld_ready  (ld_ready),
    .ld_data   (ld_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_status       = out_data.status;
  assign out_granted_page = out_data.page;
  assign out_granted_slot = out_data.slot;
  assign out_free_total   = out_data.free_total;

endmodule

### sv/ssa_checker.sv
// Port-level checker for the slab slot allocator and its bind
`include "slab_slot_allocator_defines.svh"

module ssa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [1:0]                  in_req_type,
  input logic [ssa_pkg::PAGE_W-1:0]  in_page_index,
  input logic [ssa_pkg::SLOT_W-1:0]  in_slot_index,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_status,
  input logic [ssa_pkg::PAGE_W-1:0]  out_granted_page,
  input logic [ssa_pkg::SLOT_W-1:0]  out_granted_slot,
  input logic [ssa_pkg::TOTAL_W-1:0] out_free_total
);
  import ssa_pkg::*;

  // One request in flight: ready drops right after an accept
  `SSA_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // A result never appears in the cycle after its request is taken
  `SSA_ASSERT_NXT(a_no_early_result, in_valid && in_ready, !$rose(out_valid))

  // Grant fields are zero unless the request succeeded
  `SSA_ASSERT_IMP(a_grant_zero, out_valid && (out_status != ST_DONE), (out_granted_page == '0) && (out_granted_slot == '0))

  // A stalled result word holds
  `SSA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_free_total))

endmodule

bind slab_slot_allocator ssa_checker u_ssa_checker (.*);

### tb/sv/slab_slot_allocator_checker.sv
// Checker for the slab slot allocator: predicts each result word and compares it
module slab_slot_allocator_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [1:0]                  in_req_type,
  input  logic [ssa_pkg::PAGE_W-1:0]  in_page_index,
  input  logic [ssa_pkg::SLOT_W-1:0]  in_slot_index,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [1:0]                  out_status,
  input  logic [ssa_pkg::PAGE_W-1:0]  out_granted_page,
  input  logic [ssa_pkg::SLOT_W-1:0]  out_granted_slot,
  input  logic [ssa_pkg::TOTAL_W-1:0] out_free_total,
  input  logic                        drain_check,
  output int                          fail_count,
  output int                          pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import ssa_pkg::*;

  // Shadow of the pool: bitmaps, counts, list membership and links
  logic [SLOTS_PER_PAGE-1:0] slot_map [PAGES];
  int unsigned               free_cnt [PAGES];
  logic [1:0]                list_of  [PAGES];
  link_t                     fwd      [PAGES];
  link_t                     bwd      [PAGES];
  link_t                     head_of  [LIST_N];
  link_t                     tail_of  [LIST_N];
  int unsigned               pool_free;

  result_t expected_words [$];
  bit      drain_seen;

  initial begin
    fail_count = 0;
    pending    = 0;
    drain_seen = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got_v, input int exp_v);
    $display("%0t slab_slot_allocator_checker: %s got %0d expected %0d",
             $time, what, got_v, exp_v);
    fail_count++;
  endtask

  // Empty, partly used and full lists sit at index 0, 1, 2
  function automatic int list_slot(input logic [1:0] tag);
    return (int'(tag) + 2) % 3;
  endfunction

  function automatic void unlink_page(input int p);
    int    l;
    link_t nx;
    link_t pv;
    l  = list_slot(list_of[p]);
    nx = fwd[p];
    pv = bwd[p];
    if (pv != NIL) fwd[pv] = nx;
    else head_of[l] = nx;
    if (nx != NIL) bwd[nx] = pv;
    else tail_of[l] = pv;
    fwd[p] = NIL;
    bwd[p] = NIL;
  endfunction

  function automatic void append_page(input int p, input logic [1:0] tag);
    int    l;
    link_t t;
    l      = list_slot(tag);
    t      = tail_of[l];
    bwd[p] = t;
    fwd[p] = NIL;
    if (t != NIL) fwd[t] = link_t'(p);
    else head_of[l] = link_t'(p);
    tail_of[l] = link_t'(p);
    list_of[p] = tag;
  endfunction

  // Relink only when the page actually changes list
  function automatic void move_page(input int p, input logic [1:0] tag);
    if (list_of[p] != tag) begin
      unlink_page(p);
      append_page(p, tag);
    end
  endfunction

  // Apply one request to the shadow pool and return the word it yields
  function automatic result_t serve_request(input logic [1:0] req, input int pg, input int sl);
    result_t r;
    link_t   head;
    int      p;
    bit      found;
    r        = '0;
    r.status = ST_INVALID;
    case (req)
      REQ_ALLOC: begin
        head = head_of[list_slot(TAG_PART)];
        if (head == NIL) head = head_of[list_slot(TAG_EMPTY)];
        r.status = ST_NO_SLOT;
        if (head != NIL) begin
          p     = int'(head);
          found = 1'b0;
          for (int i = 0; i < SLOTS_PER_PAGE; i++) begin
            if (!found && !slot_map[p][i]) begin
              found          = 1'b1;
              slot_map[p][i] = 1'b1;
              if (free_cnt[p] > 0) free_cnt[p]--;
              if (pool_free > 0) pool_free--;
              move_page(p, (free_cnt[p] == 0) ? TAG_FULL : TAG_PART);
              r.status = ST_DONE;
              r.page   = PAGE_W'(p);
              r.slot   = SLOT_W'(i);
            end
          end
        end
      end
      REQ_FREE: begin
        if (pg < PAGES && sl < SLOTS_PER_PAGE && list_of[pg] != TAG_NONE &&
            slot_map[pg][sl]) begin
          slot_map[pg][sl] = 1'b0;
          if (free_cnt[pg] < SLOTS_PER_PAGE) free_cnt[pg]++;
          pool_free++;
          move_page(pg, (free_cnt[pg] == SLOTS_PER_PAGE) ? TAG_EMPTY : TAG_PART);
          r.status = ST_DONE;
        end
      end
      REQ_ADD: begin
        if (pg < PAGES && list_of[pg] == TAG_NONE) begin
          slot_map[pg] = '0;
          free_cnt[pg] = SLOTS_PER_PAGE;
          pool_free    = pool_free + SLOTS_PER_PAGE;
          append_page(pg, TAG_EMPTY);
          r.status = ST_DONE;
        end
      end
      default: ;
    endcase
    r.free_total = TOTAL_W'(pool_free);
    return r;
  endfunction

  // Watch both channels; results are checked before the new request is queued
  always @(posedge clk) begin
    result_t exp_w;
    if (!rst_n) begin
      for (int i = 0; i < PAGES; i++) begin
        slot_map[i] = '0;
        free_cnt[i] = 0;
        list_of[i]  = TAG_NONE;
        fwd[i]      = NIL;
        bwd[i]      = NIL;
      end
      for (int i = 0; i < LIST_N; i++) begin
        head_of[i] = NIL;
        tail_of[i] = NIL;
      end
      pool_free = 0;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("result word with no request waiting, status",
                          int'(out_status), -1);
        end else begin
          exp_w = expected_words.pop_front();
          if (out_status != exp_w.status)
            report_mismatch("status", int'(out_status), int'(exp_w.status));
          if (out_granted_page != exp_w.page)
            report_mismatch("granted_page", int'(out_granted_page), int'(exp_w.page));
          if (out_granted_slot != exp_w.slot)
            report_mismatch("granted_slot", int'(out_granted_slot), int'(exp_w.slot));
          if (out_free_total != exp_w.free_total)
            report_mismatch("free_total", int'(out_free_total), int'(exp_w.free_total));
        end
      end
      if (in_valid && in_ready)
        expected_words.push_back(serve_request(in_req_type, int'(in_page_index),
                                               int'(in_slot_index)));
      // Anything still queued at the end never got its result
      if (drain_check && !drain_seen) begin
        drain_seen = 1'b1;
        if (expected_words.size() != 0)
          report_mismatch("words still outstanding at end, count", 0, expected_words.size());
      end
    end
    pending <= expected_words.size();
  end

endmodule

### tb/sv/slab_slot_allocator_tb.sv
// Top of the slab slot allocator testbench: clock, reset, stimulus and verdict
module slab_slot_allocator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ssa_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN  = 2'd3;
  localparam int         RANDOM_WORDS = 680;
  localparam int         LIMIT_CYCLES = 400000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         HOLD_AT      = 250;
  localparam int         PAUSE_AT     = 450;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_req_type;
  logic [PAGE_W-1:0]  in_page_index;
  logic [SLOT_W-1:0]  in_slot_index;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic [PAGE_W-1:0]  out_granted_page;
  logic [SLOT_W-1:0]  out_granted_slot;
  logic [TOTAL_W-1:0] out_free_total;
  logic               drain_check;
  int                 fail_count;
  int                 pending;
  int                 cycle_cnt;

  // Receiver hold-off flag, lets the sender run flat out meanwhile
  logic hold_active;
  bit   sender_burst;

  // Slots the stimulus believes granted, for well-formed frees
  logic [SLOTS_PER_PAGE-1:0] held_slots [PAGES];
  logic [1:0]                sent_kinds [$];

  slab_slot_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_page_index    (in_page_index),
    .in_slot_index    (in_slot_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_granted_page (out_granted_page),
    .out_granted_slot (out_granted_slot),
    .out_free_total   (out_free_total)
  );

  slab_slot_allocator_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_page_index    (in_page_index),
    .in_slot_index    (in_slot_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_granted_page (out_granted_page),
    .out_granted_slot (out_granted_slot),
    .out_free_total   (out_free_total),
    .drain_check      (drain_check),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Run limit
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("slab_slot_allocator_tb: done, errors");
      $finish;
    end
  end

  // Track granted slots from the result channel, released ones from the request channel
  initial begin
    for (int i = 0; i < PAGES; i++) held_slots[i] = '0;
  end

  always @(posedge clk) begin
    logic [1:0] kind;
    if (rst_n) begin
      if (out_valid && out_ready && sent_kinds.size() != 0) begin
        kind = sent_kinds.pop_front();
        if (kind == REQ_ALLOC && out_status == ST_DONE)
          held_slots[out_granted_page][out_granted_slot] = 1'b1;
      end
      if (in_valid && in_ready) begin
        sent_kinds.push_back(in_req_type);
        if (in_req_type == REQ_FREE)
          held_slots[in_page_index][in_slot_index] = 1'b0;
      end
    end
  end

  // Gap before a word; no gap while the receiver is holding off
  task automatic idle_gap();
    int gap;
    gap = (hold_active || sender_burst) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Present one word and hold it until accepted
  task automatic offer(input logic [1:0] r, input logic [PAGE_W-1:0] p,
                       input logic [SLOT_W-1:0] s);
    in_req_type   <= r;
    in_page_index <= p;
    in_slot_index <= s;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic directed(input logic [1:0] r, input logic [PAGE_W-1:0] p,
                          input logic [SLOT_W-1:0] s);
    idle_gap();
    offer(r, p, s);
  endtask

  // Random request; segments alternate between filling and draining the pool
  task automatic pick_request(input int n, output logic [1:0] r,
                              output logic [PAGE_W-1:0] p, output logic [SLOT_W-1:0] s);
    int roll;
    int alloc_pct;
    int held;
    int k;
    roll      = $urandom_range(0, 99);
    alloc_pct = ((n / 100) % 2 == 0) ? 75 : 20;
    r         = REQ_FREE;
    p         = PAGE_W'($urandom_range(0, PAGES - 1));
    s         = SLOT_W'($urandom_range(0, SLOTS_PER_PAGE - 1));
    if (roll < 4) begin
      r = REQ_UNKNOWN;
    end else if (roll < 7) begin
      r = REQ_ADD;
    end else if (roll < 7 + alloc_pct) begin
      r = REQ_ALLOC;
    end else if (roll < 95) begin
      // free a slot believed granted, else fall back to a random free
      held = 0;
      for (int i = 0; i < PAGES; i++)
        for (int j = 0; j < SLOTS_PER_PAGE; j++)
          if (held_slots[i][j]) held++;
      if (held > 0) begin
        k = $urandom_range(0, held - 1);
        for (int i = 0; i < PAGES; i++)
          for (int j = 0; j < SLOTS_PER_PAGE; j++)
            if (held_slots[i][j]) begin
              if (k == 0) begin
                p = PAGE_W'(i);
                s = SLOT_W'(j);
              end
              k--;
            end
      end
    end
  endtask

  // Sender: reset, directed words, random words, drain and verdict
  initial begin
    logic [1:0]        r;
    logic [PAGE_W-1:0] p;
    logic [SLOT_W-1:0] s;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_req_type   <= REQ_ALLOC;
    in_page_index <= '0;
    in_slot_index <= '0;
    drain_check   <= 1'b0;
    sender_burst  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pool, misuse cases, list moves
    directed(REQ_ALLOC,   4'd15, 6'd63);  // nothing added: no free slot
    directed(REQ_FREE,    4'd3,  6'd0);   // page never added
    directed(REQ_UNKNOWN, 4'd15, 6'd63);  // unknown request type
    directed(REQ_ADD,     4'd0,  6'd63);
    directed(REQ_ADD,     4'd0,  6'd0);   // added twice
    directed(REQ_ADD,     4'd15, 6'd0);
    directed(REQ_ALLOC,   4'd15, 6'd63);  // page field ignored
    directed(REQ_ALLOC,   4'd0,  6'd0);
    directed(REQ_FREE,    4'd0,  6'd0);
    directed(REQ_FREE,    4'd0,  6'd0);   // already free
    directed(REQ_ALLOC,   4'd9,  6'd21);  // lowest free slot again
    directed(REQ_FREE,    4'd0,  6'd63);  // already free, top slot
    directed(REQ_FREE,    4'd15, 6'd63);  // free slot on an empty page
    directed(REQ_FREE,    4'd0,  6'd1);
    directed(REQ_FREE,    4'd0,  6'd0);   // page back to the empty list tail
    directed(REQ_ALLOC,   4'd0,  6'd0);   // head of the empty list now page 15
    directed(REQ_ALLOC,   4'd0,  6'd0);
    directed(REQ_ADD,     4'd7,  6'd42);
    directed(REQ_UNKNOWN, 4'd0,  6'd0);
    directed(REQ_FREE,    4'd15, 6'd1);
    directed(REQ_ALLOC,   4'd5,  6'd10);  // partly used list first

    // Random words
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 60 == 0) sender_burst = ($urandom_range(0, 3) == 0);
      if (n == PAUSE_AT) begin
        // pause until every outstanding word has come back
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      idle_gap();
      pick_request(n, r, p, s);
      offer(r, p, s);
    end
    in_valid <= 1'b0;

    // Drain, then allow for the block's latency
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    drain_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("slab_slot_allocator_tb: done, clean");
    end else begin
      $display("slab_slot_allocator_tb: done, errors");
    end
    $finish;
  end

  // Receiver: random stalls per word, bursts, and one long hold-off
  initial begin
    int  gap;
    int  got;
    bit  recv_burst;
    bit  hold_done;
    got         = 0;
    recv_burst  = 1'b0;
    hold_done   = 1'b0;
    out_ready   <= 1'b0;
    hold_active <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (got % 60 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      gap = recv_burst ? 0 : $urandom_range(0, 16);
      if (got == HOLD_AT && !hold_done) begin
        hold_done   = 1'b1;
        hold_active <= 1'b1;
        out_ready   <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got++;
    end
  end

endmodule
